### rtl/gtsa_pkg.sv
`timescale 1ns / 1ps
// gtsa_pkg: shared types and codes of the generation tagged slot allocator
// used by gtsa_exec and the top level; depends on nothing

package gtsa_pkg;

   localparam int ID_W   = 31;
   localparam int RUNS_W = 32;

   // command codes
   localparam logic [1:0] CMD_ALLOC  = 2'd0;
   localparam logic [1:0] CMD_FREE   = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;
   localparam logic [1:0] CMD_RUN    = 2'd3;

   // response status codes
   localparam logic [1:0] RSP_OK      = 2'd0;
   localparam logic [1:0] RSP_NO_FREE = 2'd1;
   localparam logic [1:0] RSP_BAD_ID  = 2'd2;

   // generation step added on every allocation
   localparam logic [31:0] GEN_STEP = 32'd4096;

   typedef struct packed {
      logic [1:0]      cmd;
      logic [ID_W-1:0] target_id;
      logic [ID_W-1:0] owner_id;
      logic            check_perm;
   } cmd_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ID_W-1:0]   result_id;
      logic [RUNS_W-1:0] run_count;
   } rsp_type;

   // slot entry without the free list link
   typedef struct packed {
      logic              live;
      logic [ID_W-1:0]   id;
      logic [ID_W-1:0]   parent;
      logic [RUNS_W-1:0] runs;
   } entry_type;

endpackage

### rtl/gtsa_mem.sv
`timescale 1ns / 1ps
// gtsa_mem: single port write, single port read slot memory
// read data is registered; no dependencies

module gtsa_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 106
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/gtsa_exec.sv
`timescale 1ns / 1ps
// gtsa_exec: command evaluation on the slot entry read from gtsa_mem
// produces the response, the write-back and the next head/current state; uses gtsa_pkg

module gtsa_exec #(
   parameter int SLOTS = 1024,
   localparam int AW = $clog2(SLOTS),
   localparam int IW = $clog2(SLOTS + 1)
) (
   input  gtsa_pkg::cmd_type             cmd,
   input  logic [AW-1:0]                 addr,
   input  gtsa_pkg::entry_type           rd_entry,
   input  logic [IW-1:0]                 rd_next,
   input  logic [IW-1:0]                 free_head,
   input  logic [IW-1:0]                 cur_slot,
   input  logic [gtsa_pkg::ID_W-1:0]     cur_id,
   output gtsa_pkg::rsp_type             rsp,
   output logic                          wr_en,
   output gtsa_pkg::entry_type           wr_entry,
   output logic [IW-1:0]                 wr_next,
   output logic [IW-1:0]                 head_nxt,
   output logic [IW-1:0]                 cur_slot_nxt,
   output logic [gtsa_pkg::ID_W-1:0]     cur_id_nxt
);

   import gtsa_pkg::*;

   localparam logic [IW-1:0] NUL_SLOT = IW'(SLOTS);

   logic [ID_W-1:0] idx_full;
   logic            idx_ok;
   logic            cur_live;
   logic            head_live;
   logic            tid_zero;
   logic            found;
   logic [IW-1:0]   addr_ext;
   logic [31:0]     gen_sum;
   logic [31:0]     gen_masked;
   logic [31:0]     gen;
   logic [ID_W-1:0] new_id;

   assign idx_full  = cmd.target_id & ID_W'(SLOTS - 1);
   assign idx_ok    = idx_full < ID_W'(SLOTS);
   assign cur_live  = cur_slot != NUL_SLOT;
   assign head_live = free_head != NUL_SLOT;
   assign tid_zero  = cmd.target_id == '0;
   assign addr_ext  = IW'(addr);

   // id zero stands for the current slot, whose entry was read
   assign found = tid_zero ? cur_live
                           : (idx_ok && rd_entry.live && (rd_entry.id == cmd.target_id));

   assign gen_sum    = 32'(rd_entry.id) + GEN_STEP;
   assign gen_masked = gen_sum & ~32'(SLOTS - 1);
   assign gen        = ((gen_masked == '0) || gen_masked[31]) ? GEN_STEP : gen_masked;
   assign new_id     = ID_W'(gen | 32'(addr));

   always_comb begin
      rsp          = '0;
      rsp.status   = RSP_OK;
      wr_en        = 1'b0;
      wr_entry     = rd_entry;
      wr_next      = rd_next;
      head_nxt     = free_head;
      cur_slot_nxt = cur_slot;
      cur_id_nxt   = cur_id;
      case (cmd.cmd)
         CMD_ALLOC: begin
            if (!head_live) begin
               rsp.status = RSP_NO_FREE;
            end else begin
               wr_en           = 1'b1;
               wr_entry.live   = 1'b1;
               wr_entry.id     = new_id;
               wr_entry.parent = cmd.owner_id;
               wr_entry.runs   = '0;
               head_nxt        = rd_next;
               rsp.result_id   = new_id;
            end
         end
         CMD_FREE: begin
            if (!found) begin
               rsp.status = RSP_BAD_ID;
            end else begin
               wr_en         = 1'b1;
               wr_entry.live = 1'b0;
               wr_next       = free_head;
               head_nxt      = addr_ext;
               if (cur_slot == addr_ext) begin
                  cur_slot_nxt = NUL_SLOT;
               end
            end
         end
         CMD_LOOKUP: begin
            if (tid_zero) begin
               rsp.result_id = cur_live ? cur_id : '0;
            end else if (!found) begin
               rsp.status = RSP_BAD_ID;
            end else if (cmd.check_perm && (!cur_live ||
                         ((addr_ext != cur_slot) && (rd_entry.parent != cur_id)))) begin
               rsp.status = RSP_BAD_ID;
            end else begin
               rsp.result_id = rd_entry.id;
            end
         end
         CMD_RUN: begin
            // the old current slot turns runnable implicitly: running means current
            if (!found) begin
               rsp.status = RSP_BAD_ID;
            end else begin
               wr_en         = 1'b1;
               wr_entry.runs = rd_entry.runs + RUNS_W'(1);
               cur_slot_nxt  = addr_ext;
               cur_id_nxt    = rd_entry.id;
               rsp.run_count = rd_entry.runs + RUNS_W'(1);
            end
         end
      endcase
   end

endmodule

### rtl/generation_tagged_slot_allocator_core.sv
`timescale 1ns / 1ps
// generation_tagged_slot_allocator_core: top level with control, clearing sweep,
// response register; uses gtsa_pkg, gtsa_mem and gtsa_exec

// Usage
//   req channel: one command beat (alloc, free, lookup, run) per handshake.
//   rsp channel: exactly one response beat per command, in command order.
//   When a command is accepted, the slot entry it names (the free list head for
//   alloc, the current slot for id zero) is read from the slot memory. In the
//   evaluation state that follows, the entry is evaluated, written back and the
//   response is loaded into the output register, which drives rsp_tvalid. A new
//   command is taken only after the previous one has been evaluated.
//   The output register decouples the sides: a new command is taken while a
//   response waits; the evaluation cycle holds only while the output register is
//   full and rsp_tready is low.
//   After reset a clearing sweep writes every slot entry (free, zero id, link to
//   the next slot), one per cycle; req_tready stays low meanwhile. Ids hold the
//   slot index in their low bits and the generation above.

module generation_tagged_slot_allocator_core #(
   parameter int SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // target_id[30:0], owner_id[61:31], check_perm[62], zero
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // status[1:0], result_id[32:2], run_count[64:33], zero
);

   import gtsa_pkg::*;

   localparam int AW = $clog2(SLOTS);
   localparam int IW = $clog2(SLOTS + 1);
   localparam int EW = $bits(entry_type);
   localparam int MW = IW + EW;
   localparam logic [IW-1:0] NUL_SLOT = IW'(SLOTS);

   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]      state_ff, state_in;
   logic [AW-1:0]   sweep_ff, sweep_in;
   cmd_type         cmd_ff, cmd_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [IW-1:0]   head_ff, head_in;
   logic [IW-1:0]   cur_ff, cur_in;
   logic [ID_W-1:0] cur_id_ff, cur_id_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            req_acc;
   logic            commit;
   logic [AW-1:0]   rd_addr;
   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   logic [MW-1:0]   mem_wr_data;
   logic [MW-1:0]   mem_rd_data;
   entry_type       rd_entry;
   logic [IW-1:0]   rd_next;

   rsp_type         ex_rsp;
   logic            ex_wr_en;
   entry_type       ex_wr_entry;
   logic [IW-1:0]   ex_wr_next;
   logic [IW-1:0]   ex_head_nxt;
   logic [IW-1:0]   ex_cur_nxt;
   logic [ID_W-1:0] ex_cur_id_nxt;

   assign req_tready = state_ff == ST_IDLE;
   assign req_acc    = req_tvalid && req_tready;
   assign commit     = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      cmd_in.cmd        = req_tuser;
      cmd_in.target_id  = req_tdata[30:0];
      cmd_in.owner_id   = req_tdata[61:31];
      cmd_in.check_perm = req_tdata[62];
   end

   // entry to fetch: free list head, current slot for id zero, else the id's slot
   always_comb begin
      if (cmd_in.cmd == CMD_ALLOC) begin
         rd_addr = head_ff[AW-1:0];
      end else if (cmd_in.target_id == '0) begin
         rd_addr = cur_ff[AW-1:0];
      end else begin
         rd_addr = AW'(cmd_in.target_id & ID_W'(SLOTS - 1));
      end
   end
   assign addr_in = rd_addr;

   always_comb begin
      if (state_ff == ST_SWEEP) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = sweep_ff;
         mem_wr_data = {IW'(sweep_ff) + IW'(1), EW'(0)};
      end else begin
         mem_wr_en   = commit && ex_wr_en;
         mem_wr_addr = addr_ff;
         mem_wr_data = {ex_wr_next, ex_wr_entry};
      end
   end

   gtsa_mem #(
      .DEPTH (SLOTS),
      .WIDTH (MW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_acc),
      .rd_addr (rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rd_entry = mem_rd_data[EW-1:0];
   assign rd_next  = mem_rd_data[MW-1:EW];

   gtsa_exec #(
      .SLOTS (SLOTS)
   ) u_exec (
      .cmd          (cmd_ff),
      .addr         (addr_ff),
      .rd_entry     (rd_entry),
      .rd_next      (rd_next),
      .free_head    (head_ff),
      .cur_slot     (cur_ff),
      .cur_id       (cur_id_ff),
      .rsp          (ex_rsp),
      .wr_en        (ex_wr_en),
      .wr_entry     (ex_wr_entry),
      .wr_next      (ex_wr_next),
      .head_nxt     (ex_head_nxt),
      .cur_slot_nxt (ex_cur_nxt),
      .cur_id_nxt   (ex_cur_id_nxt)
   );

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign head_in      = commit ? ex_head_nxt : head_ff;
   assign cur_in       = commit ? ex_cur_nxt : cur_ff;
   assign cur_id_in    = commit ? ex_cur_id_nxt : cur_id_ff;
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = commit ? ex_rsp : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         head_ff      <= '0;
         cur_ff       <= NUL_SLOT;
         cur_id_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         head_ff      <= head_in;
         cur_ff       <= cur_in;
         cur_id_ff    <= cur_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff  <= cmd_in;
         addr_ff <= addr_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.run_count, rsp_ff.result_id, rsp_ff.status};

`ifndef NO_ASSERTIONS
   a_acc_exec: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_EXEC))
      else $error("accepted command did not enter evaluation");

   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("evaluated command gave no response beat");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SWEEP) |-> (head_ff <= NUL_SLOT))
      else $error("free list head out of range");

   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= NUL_SLOT)
      else $error("current slot out of range");

   a_wr_when: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((state_ff == ST_SWEEP) || commit))
      else $error("slot memory written outside sweep or commit");
`endif

endmodule

### tb/tb_generation_tagged_slot_allocator_core.sv
`timescale 1ns / 1ps
// tb_generation_tagged_slot_allocator_core: self-checking bench for the slot allocator,
// with a clocked driver, a clocked monitor and its own model of the slot table
// depends on gtsa_pkg and generation_tagged_slot_allocator_core

module tb_generation_tagged_slot_allocator_core;
   import gtsa_pkg::*;

   localparam int SLOTS  = 1024;
   localparam int SLOT_W = $clog2(SLOTS) + 1;
   localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(SLOTS);
   localparam logic [ID_W-1:0] GEN1 = ID_W'(GEN_STEP);

   typedef enum logic [1:0] {SLOT_FREE, SLOT_RUNNABLE, SLOT_RUNNING} slot_state_e;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // target_id[30:0], owner_id[61:31], check_perm[62], zero
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // status[1:0], result_id[32:2], run_count[64:33], zero

   // model of the slot table
   slot_state_e       slot_state  [SLOTS];
   logic [ID_W-1:0]   slot_gen_id [SLOTS];
   logic [ID_W-1:0]   slot_owner  [SLOTS];
   logic [SLOT_W-1:0] slot_link   [SLOTS];
   logic [RUNS_W-1:0] slot_runs   [SLOTS];
   logic [SLOT_W-1:0] free_top;
   logic [SLOT_W-1:0] cur_slot;
   int                hi_mark;

   cmd_type cmd_backlog[$];
   rsp_type rsp_expected[$];
   cmd_type drv_item;
   int      sent_cnt = 0;
   int      got_cnt = 0;
   int      mismatches = 0;
   int      hold_left = 0;

   always #5 clock = ~clock;

   generation_tagged_slot_allocator_core #(.SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic logic [SLOT_W-1:0] resolve_id(logic [ID_W-1:0] id);
      logic [SLOT_W-1:0] idx;
      if (id == '0) return cur_slot;
      idx = SLOT_W'(id & ID_W'(SLOTS - 1));
      if (slot_state[idx] == SLOT_FREE || slot_gen_id[idx] != id) return NO_SLOT;
      return idx;
   endfunction

   function automatic rsp_type next_response(cmd_type c);
      rsp_type           r;
      logic [SLOT_W-1:0] idx;
      logic [31:0]       gen;
      r = '0;
      r.status = RSP_OK;
      case (c.cmd)
         CMD_ALLOC: begin
            if (free_top == NO_SLOT) begin
               r.status = RSP_NO_FREE;
            end else begin
               idx = free_top;
               gen = ({1'b0, slot_gen_id[idx]} + GEN_STEP) & ~(32'(SLOTS) - 32'd1);
               if (gen == '0 || gen[31]) gen = GEN_STEP;
               slot_gen_id[idx] = gen[ID_W-1:0] | ID_W'(idx);
               slot_owner[idx]  = c.owner_id;
               slot_state[idx]  = SLOT_RUNNABLE;
               slot_runs[idx]   = '0;
               free_top         = slot_link[idx];
               r.result_id      = slot_gen_id[idx];
               if (int'(idx) > hi_mark) hi_mark = int'(idx);
            end
         end
         CMD_FREE: begin
            idx = resolve_id(c.target_id);
            if (idx == NO_SLOT) begin
               r.status = RSP_BAD_ID;
            end else begin
               slot_state[idx] = SLOT_FREE;
               slot_link[idx]  = free_top;
               free_top        = idx;
               if (cur_slot == idx) cur_slot = NO_SLOT;
            end
         end
         CMD_LOOKUP: begin
            if (c.target_id == '0) begin
               if (cur_slot != NO_SLOT) r.result_id = slot_gen_id[cur_slot];
            end else begin
               idx = resolve_id(c.target_id);
               if (idx == NO_SLOT) begin
                  r.status = RSP_BAD_ID;
               end else if (c.check_perm && (cur_slot == NO_SLOT ||
                            (idx != cur_slot && slot_owner[idx] != slot_gen_id[cur_slot]))) begin
                  r.status = RSP_BAD_ID;
               end else begin
                  r.result_id = slot_gen_id[idx];
               end
            end
         end
         default: begin
            idx = resolve_id(c.target_id);
            if (idx == NO_SLOT) begin
               r.status = RSP_BAD_ID;
            end else begin
               if (cur_slot != NO_SLOT && slot_state[cur_slot] == SLOT_RUNNING)
                  slot_state[cur_slot] = SLOT_RUNNABLE;
               cur_slot        = idx;
               slot_state[idx] = SLOT_RUNNING;
               slot_runs[idx]  = slot_runs[idx] + 1'b1;
               r.run_count     = slot_runs[idx];
            end
         end
      endcase
      return r;
   endfunction

   function automatic cmd_type cmd_beat(logic [1:0] op, logic [ID_W-1:0] tid,
                                        logic [ID_W-1:0] pid, logic chk);
      cmd_type c;
      c.cmd        = op;
      c.target_id  = tid;
      c.owner_id   = pid;
      c.check_perm = chk;
      return c;
   endfunction

   function automatic logic [ID_W-1:0] live_id();
      int idx;
      for (int k = 0; k < 16; k++) begin
         idx = $urandom_range(hi_mark);
         if (slot_state[idx] != SLOT_FREE) return slot_gen_id[idx];
      end
      return ID_W'($urandom);
   endfunction

   function automatic logic [ID_W-1:0] pick_target();
      int roll;
      int idx;
      roll = $urandom_range(99);
      idx  = $urandom_range(hi_mark);
      if (roll < 10) return '0;
      // stale generation or an id whose slot may have been freed
      if (roll < 16) return slot_gen_id[idx] - GEN1;
      if (roll < 22) return slot_gen_id[idx];
      if (roll < 30) return ID_W'($urandom);
      return live_id();
   endfunction

   function automatic cmd_type make_cmd(int alloc_pct, int free_pct);
      cmd_type c;
      int      roll;
      roll = $urandom_range(99);
      if (roll < alloc_pct) c.cmd = CMD_ALLOC;
      else if (roll < alloc_pct + free_pct) c.cmd = CMD_FREE;
      else if ($urandom_range(1) == 1) c.cmd = CMD_LOOKUP;
      else c.cmd = CMD_RUN;
      c.target_id = pick_target();
      roll = $urandom_range(99);
      // children of the current slot give the ownership check something to pass
      if (roll < 40 && cur_slot != NO_SLOT) c.owner_id = slot_gen_id[cur_slot];
      else if (roll < 60) c.owner_id = live_id();
      else if (roll < 70) c.owner_id = '0;
      else c.owner_id = ID_W'($urandom);
      c.check_perm = 1'($urandom_range(1));
      return c;
   endfunction

   task automatic offer_cmd(cmd_type c);
      while (cmd_backlog.size() >= 4) @(negedge clock);
      cmd_backlog.push_back(c);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_tvalid || rsp_expected.size() != 0);
   endtask

   always @(posedge clock) begin : req_driver
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rsp_expected.push_back(next_response(drv_item));
            sent_cnt++;
         end
         if (!req_tvalid || req_tready) begin
            offer = cmd_backlog.size() > 0 &&
                    !($urandom_range(99) < 6 && !(sent_cnt >= 1200 && sent_cnt < 1600));
            if (offer) begin
               drv_item = cmd_backlog.pop_front();
               req_tdata <= {1'b0, drv_item.check_perm, drv_item.owner_id, drv_item.target_id};
               req_tuser <= drv_item.cmd;
            end
            req_tvalid <= offer;
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      rsp_type want;
      logic    ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tdata[1:0];
            got.result_id = rsp_tdata[32:2];
            got.run_count = rsp_tdata[64:33];
            if (rsp_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat: status %0d id %h runs %0d",
                           got.status, got.result_id, got.run_count);
            end else begin
               want = rsp_expected.pop_front();
               if (got.status != want.status || got.result_id != want.result_id ||
                   got.run_count != want.run_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("beat %0d: exp st %0d id %h runs %0d, got st %0d id %h runs %0d",
                              got_cnt, want.status, want.result_id, want.run_count,
                              got.status, got.result_id, got.run_count);
               end
            end
            got_cnt++;
            // long back-pressure so the block fills and stalls its input
            if (got_cnt == 400) hold_left = 500;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            ready_next = !($urandom_range(99) < 6 && !(got_cnt >= 1000 && got_cnt < 1400));
         end
         rsp_tready <= ready_next;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int n;
      int extra;
      for (int i = 0; i < SLOTS; i++) begin
         slot_state[i]  = SLOT_FREE;
         slot_gen_id[i] = '0;
         slot_owner[i]  = '0;
         slot_link[i]   = SLOT_W'(i + 1);
         slot_runs[i]   = '0;
      end
      free_top = '0;
      cur_slot = NO_SLOT;
      hi_mark  = 0;

      // no current slot yet
      offer_cmd(cmd_beat(CMD_LOOKUP, '0, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_LOOKUP, '0, '0, 1'b1));
      offer_cmd(cmd_beat(CMD_FREE, '0, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_RUN, '0, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_ALLOC, '1, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_ALLOC, '0, GEN1, 1'b0));
      offer_cmd(cmd_beat(CMD_ALLOC, '0, '1, 1'b1));
      offer_cmd(cmd_beat(CMD_LOOKUP, GEN1 + 1'b1, '0, 1'b1));
      // ownership: current, child and unrelated slot
      offer_cmd(cmd_beat(CMD_RUN, GEN1, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_LOOKUP, GEN1 + 1'b1, '0, 1'b1));
      offer_cmd(cmd_beat(CMD_LOOKUP, GEN1 + 2'd2, '0, 1'b1));
      offer_cmd(cmd_beat(CMD_LOOKUP, GEN1, '0, 1'b1));
      offer_cmd(cmd_beat(CMD_LOOKUP, '0, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_RUN, GEN1, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_RUN, GEN1 + 1'b1, '0, 1'b0));
      // freeing the current slot, then stale ids and reuse of the slot
      offer_cmd(cmd_beat(CMD_FREE, '0, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_LOOKUP, GEN1 + 1'b1, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_ALLOC, '0, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_LOOKUP, GEN1 + 1'b1, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_RUN, (GEN1 << 1) + 1'b1, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_FREE, GEN1 + 2'd2, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_FREE, GEN1 + 2'd2, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_LOOKUP, '1, '0, 1'b0));
      offer_cmd(cmd_beat(CMD_RUN, ID_W'(SLOTS), '0, 1'b0));

      for (int i = 0; i < 500; i++) offer_cmd(make_cmd(35, 25));
      // sender pause until the pipeline is empty
      wait_drained();

      // fill the table and keep knocking on it while full
      n = 0;
      extra = 0;
      while (extra < 80 && n < 1600) begin
         offer_cmd(make_cmd(88, 2));
         if (extra > 0 || free_top == NO_SLOT) extra++;
         n++;
      end

      for (int i = 0; i < 300; i++) offer_cmd(make_cmd(15, 60));

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
